// ===== rtl/crc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_pkg: shared types, constants and table builder
// Field widths, register defaults, item structs and the sRGB linearization
// table used by the contrast ratio checker.
// ----------------------------------------------------------------------------
package crc_pkg;

   localparam int unsigned CHANNEL_BITS_DEFAULT    = 8;
   localparam int unsigned RATIO_FRAC_BITS_DEFAULT = 12;

   localparam int unsigned CODE_BITS        = 8;
   localparam int unsigned ROM_DEPTH        = 256;
   localparam int unsigned LIN_BITS         = 17;
   localparam int unsigned REG_BITS         = 17;
   localparam int unsigned LUM_BITS         = 17;
   localparam int unsigned WEIGHT_FRAC_BITS = 16;
   localparam int unsigned PROD_BITS        = REG_BITS + LIN_BITS;
   localparam int unsigned SUM_BITS         = PROD_BITS + 2;
   localparam int unsigned TERM_BITS        = 22;
   localparam int unsigned RATIO_BITS       = 17;
   localparam int unsigned RATIO_INT_BITS   = 5;
   localparam int unsigned REM_BITS         = TERM_BITS + RATIO_BITS;
   localparam int unsigned CSR_INDEX_BITS   = 2;
   localparam int unsigned LUMA_STAGES      = 3;

   localparam logic [REG_BITS-1:0] RED_WEIGHT_RESET     = 17'd13933;
   localparam logic [REG_BITS-1:0] GREEN_WEIGHT_RESET   = 17'd46871;
   localparam logic [REG_BITS-1:0] BLUE_WEIGHT_RESET    = 17'd4732;
   localparam logic [REG_BITS-1:0] PASS_THRESHOLD_RESET = 17'd18432;

   // 1.0 in Q6.16, the scaled form of the 0.05 offset after multiplying by 20.
   localparam logic [TERM_BITS-1:0] TERM_ONE = 22'd65536;
   localparam logic [LUM_BITS-1:0]  LUM_MAX  = '1;

   // Curve construction constants.
   localparam int unsigned LIN_KNEE_CODE = 10;
   localparam logic [63:0] LIN_SLOPE_DEN = 64'd32946;
   localparam logic [63:0] CURVE_DEN_SQ  = 64'd10761 * 64'd10761;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RED_WEIGHT     = 2'd0,
      CSR_GREEN_WEIGHT   = 2'd1,
      CSR_BLUE_WEIGHT    = 2'd2,
      CSR_PASS_THRESHOLD = 2'd3
   } crc_csr_index_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] fg_red;
      logic [CODE_BITS-1:0] fg_green;
      logic [CODE_BITS-1:0] fg_blue;
      logic [CODE_BITS-1:0] bg_red;
      logic [CODE_BITS-1:0] bg_green;
      logic [CODE_BITS-1:0] bg_blue;
   } crc_req_type;

   typedef struct packed {
      logic [RATIO_BITS-1:0] contrast_ratio;
      logic                  meets_guideline;
   } crc_rsp_type;

   typedef struct packed {
      logic [REG_BITS-1:0] red_weight;
      logic [REG_BITS-1:0] green_weight;
      logic [REG_BITS-1:0] blue_weight;
      logic [REG_BITS-1:0] pass_threshold;
   } crc_cfg_type;

   typedef struct packed {
      logic [REM_BITS-1:0]   rem;
      logic [TERM_BITS-1:0]  den;
      logic [RATIO_BITS-1:0] quo;
      logic                  ovf;
   } crc_div_stage_type;

   typedef logic [LIN_BITS-1:0] crc_lin_rom_type [ROM_DEPTH];

   // y^5 with y in Q0.24, truncated after each product.
   function automatic logic [63:0] crc_fifth_power(input logic [63:0] y);
      logic [63:0] p;
      p = y;
      for (int k = 0; k < 4; k++) begin
         p = (p * y) >> 24;
      end
      return p;
   endfunction

   // Linear light in Q1.16 for every 8-bit code, with the code first reduced
   // to channel_bits and rescaled to the 0..255 curve index.
   function automatic crc_lin_rom_type crc_build_lin_table(input int unsigned channel_bits);
      crc_lin_rom_type base;
      crc_lin_rom_type lut;
      logic [63:0]     num;
      logic [63:0]     sq;
      logic [63:0]     target;
      logic [63:0]     lo;
      logic [63:0]     hi;
      logic [63:0]     mid;
      logic [63:0]     maxc;
      logic [63:0]     cm;
      logic [63:0]     idx;
      for (int c = 0; c < ROM_DEPTH; c++) begin
         if (c <= LIN_KNEE_CODE) begin
            base[c] = LIN_BITS'((64'(c) * 64'd655360 + 64'd16473) / LIN_SLOPE_DEN);
         end else begin
            num    = 64'd40 * 64'(c) + 64'd561;
            sq     = ((num * num) << 32) / CURVE_DEN_SQ;
            target = sq >> 8;
            lo     = 64'd0;
            hi     = 64'd1 << 24;
            // Fifth root of v^2 gives v^0.4 by bisection.
            for (int it = 0; it < 26; it++) begin
               if (lo < hi) begin
                  mid = (lo + hi + 64'd1) >> 1;
                  if (crc_fifth_power(mid) <= target) begin
                     lo = mid;
                  end else begin
                     hi = mid - 64'd1;
                  end
               end
            end
            base[c] = LIN_BITS'((sq * lo + (64'd1 << 39)) >> 40);
         end
      end
      maxc = (64'd1 << channel_bits) - 64'd1;
      for (int c = 0; c < ROM_DEPTH; c++) begin
         cm  = 64'(c) & maxc;
         idx = 64'd0;
         for (int k = 0; k < ROM_DEPTH; k++) begin
            if (64'(k) * maxc <= cm * 64'd255) begin
               idx = 64'(k);
            end
         end
         lut[c] = base[idx[CODE_BITS-1:0]];
      end
      return lut;
   endfunction

endpackage

// ===== rtl/crc_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_csr: configuration registers
// Holds the three luminance weights and the guideline threshold.
// ----------------------------------------------------------------------------
module crc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [crc_pkg::REG_BITS-1:0]       csr_data,
   output crc_pkg::crc_cfg_type               cfg
);
   import crc_pkg::*;

   crc_cfg_type cfg_ff;
   crc_cfg_type cfg_in;

   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (crc_csr_index_type'(csr_index))
            CSR_RED_WEIGHT:     cfg_in.red_weight     = csr_data;
            CSR_GREEN_WEIGHT:   cfg_in.green_weight   = csr_data;
            CSR_BLUE_WEIGHT:    cfg_in.blue_weight    = csr_data;
            CSR_PASS_THRESHOLD: cfg_in.pass_threshold = csr_data;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_weight     <= RED_WEIGHT_RESET;
         cfg_ff.green_weight   <= GREEN_WEIGHT_RESET;
         cfg_ff.blue_weight    <= BLUE_WEIGHT_RESET;
         cfg_ff.pass_threshold <= PASS_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/crc_luma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_luma: relative luminance of both colors
// Three stages: curve lookup, weight multiply, sum with saturation.
// ----------------------------------------------------------------------------
module crc_luma #(
   parameter int unsigned CHANNEL_BITS = crc_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  crc_pkg::crc_req_type         in_data,
   input  crc_pkg::crc_cfg_type         cfg,
   output logic                         out_valid,
   output logic [crc_pkg::LUM_BITS-1:0] out_fg_lum,
   output logic [crc_pkg::LUM_BITS-1:0] out_bg_lum
);
   import crc_pkg::*;

   localparam int unsigned NUM_CODES      = 6;
   localparam int unsigned COLOR_CHANNELS = 3;
   localparam int unsigned SCALED_BITS    = SUM_BITS - WEIGHT_FRAC_BITS;
   localparam crc_lin_rom_type LIN_TABLE  = crc_build_lin_table(CHANNEL_BITS);

   logic [CODE_BITS-1:0] code [NUM_CODES];
   logic [REG_BITS-1:0]  weight [COLOR_CHANNELS];

   logic [LIN_BITS-1:0]  lin_in [NUM_CODES];
   logic [LIN_BITS-1:0]  lin_ff [NUM_CODES];
   logic [PROD_BITS-1:0] prod_in [NUM_CODES];
   logic [PROD_BITS-1:0] prod_ff [NUM_CODES];
   logic [LUM_BITS-1:0]  lum_in [2];
   logic [LUM_BITS-1:0]  lum_ff [2];
   logic [LUMA_STAGES-1:0] valid_in;
   logic [LUMA_STAGES-1:0] valid_ff;

   logic [SUM_BITS-1:0]    sum [2];
   logic [SCALED_BITS-1:0] scaled [2];

   assign code[0] = in_data.fg_red;
   assign code[1] = in_data.fg_green;
   assign code[2] = in_data.fg_blue;
   assign code[3] = in_data.bg_red;
   assign code[4] = in_data.bg_green;
   assign code[5] = in_data.bg_blue;

   assign weight[0] = cfg.red_weight;
   assign weight[1] = cfg.green_weight;
   assign weight[2] = cfg.blue_weight;

   always_comb begin
      for (int j = 0; j < NUM_CODES; j++) begin
         lin_in[j]  = LIN_TABLE[code[j]];
         prod_in[j] = PROD_BITS'(lin_ff[j]) * PROD_BITS'(weight[j % COLOR_CHANNELS]);
      end
      for (int s = 0; s < 2; s++) begin
         sum[s] = SUM_BITS'(prod_ff[3*s]) + SUM_BITS'(prod_ff[3*s+1])
                + SUM_BITS'(prod_ff[3*s+2]);
         scaled[s] = sum[s][SUM_BITS-1:WEIGHT_FRAC_BITS];
         if (scaled[s] > SCALED_BITS'(LUM_MAX)) begin
            lum_in[s] = LUM_MAX;
         end else begin
            lum_in[s] = scaled[s][LUM_BITS-1:0];
         end
      end
      valid_in = {valid_ff[LUMA_STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lin_ff  <= lin_in;
      prod_ff <= prod_in;
      lum_ff  <= lum_in;
   end

   assign out_valid  = valid_ff[LUMA_STAGES-1];
   assign out_fg_lum = lum_ff[0];
   assign out_bg_lum = lum_ff[1];

endmodule

// ===== rtl/crc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_div: pipelined restoring divider
// Quotient (num << RATIO_FRAC_BITS) / den, one quotient bit per stage, with
// an overflow flag when the quotient does not fit in RATIO_BITS.
// ----------------------------------------------------------------------------
module crc_div #(
   parameter int unsigned RATIO_FRAC_BITS = crc_pkg::RATIO_FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [crc_pkg::TERM_BITS-1:0]  in_num,
   input  logic [crc_pkg::TERM_BITS-1:0]  in_den,
   output logic                           out_valid,
   output logic [crc_pkg::RATIO_BITS-1:0] out_quo,
   output logic                           out_ovf
);
   import crc_pkg::*;

   localparam int unsigned NUM_BITS = TERM_BITS + RATIO_FRAC_BITS;

   crc_div_stage_type stage_ff [RATIO_BITS+1];
   crc_div_stage_type prep_in;
   logic [RATIO_BITS:0] valid_in;
   logic [RATIO_BITS:0] valid_ff;

   logic [NUM_BITS-1:0] scaled_num;
   logic [REM_BITS-1:0] dividend;
   logic [REM_BITS-1:0] den_top;

   always_comb begin
      scaled_num  = {in_num, {RATIO_FRAC_BITS{1'b0}}};
      dividend    = REM_BITS'(scaled_num);
      den_top     = {in_den, {RATIO_BITS{1'b0}}};
      prep_in.rem = dividend;
      prep_in.den = in_den;
      prep_in.quo = '0;
      prep_in.ovf = (dividend >= den_top);
      valid_in    = {valid_ff[RATIO_BITS-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= prep_in;
   end

   for (genvar k = 0; k < RATIO_BITS; k++) begin : g_step
      localparam int unsigned BIT = RATIO_BITS - 1 - k;
      logic [REM_BITS-1:0] shifted_den;
      logic [REM_BITS:0]   diff;
      crc_div_stage_type   stage_in;

      always_comb begin
         shifted_den = REM_BITS'(stage_ff[k].den) << BIT;
         diff        = {1'b0, stage_ff[k].rem} - {1'b0, shifted_den};
         stage_in    = stage_ff[k];
         // No borrow means the shifted divisor fits: keep the difference.
         if (!diff[REM_BITS]) begin
            stage_in.rem      = diff[REM_BITS-1:0];
            stage_in.quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[k+1] <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[RATIO_BITS];
   assign out_quo   = stage_ff[RATIO_BITS].quo;
   assign out_ovf   = stage_ff[RATIO_BITS].ovf;

endmodule

// ===== rtl/contrast_ratio_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_ratio_checker_unit: color pair contrast ratio with pass flag
// Linearizes both colors, forms relative luminances and gives the ratio
// (brighter + 0.05) / (darker + 0.05) in Q5.RATIO_FRAC_BITS, truncated.
//
//   Channel  Handshake                 Payload
//   req      start / busy              req_data  (crc_req_type)
//   rsp      rsp_valid (one cycle)     rsp_data  (crc_rsp_type)
//   csr      csr_valid / csr_ready     csr_index, csr_data
//
// One item is taken per clock while busy is low. Between an item and its
// result lie three luminance stages, the term stage, the divider (an entry
// register and 17 stages of one quotient bit each) and the output register.
// Synchronous reset clears all valid bits and restores default registers;
// busy and not csr_ready are high during reset only.
// The receiver cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module contrast_ratio_checker_unit #(
   parameter int unsigned CHANNEL_BITS    = crc_pkg::CHANNEL_BITS_DEFAULT,
   parameter int unsigned RATIO_FRAC_BITS = crc_pkg::RATIO_FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  crc_pkg::crc_req_type               req_data,
   output logic                               rsp_valid,
   output crc_pkg::crc_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [crc_pkg::REG_BITS-1:0]       csr_data
);
   import crc_pkg::*;

   localparam int unsigned LIMIT_FULL = (1 << (RATIO_INT_BITS + RATIO_FRAC_BITS)) - 1;
   localparam int unsigned RATIO_MAX  = (1 << RATIO_BITS) - 1;
   localparam logic [RATIO_BITS-1:0] RATIO_LIMIT =
      RATIO_BITS'((LIMIT_FULL > RATIO_MAX) ? RATIO_MAX : LIMIT_FULL);
   localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1 << RATIO_FRAC_BITS);
   localparam int unsigned LATENCY = LUMA_STAGES + 1 + (RATIO_BITS + 1) + 1;

   crc_cfg_type cfg;

   logic                 in_valid;
   logic                 lum_valid;
   logic [LUM_BITS-1:0]  fg_lum;
   logic [LUM_BITS-1:0]  bg_lum;
   logic [LUM_BITS-1:0]  lum_hi;
   logic [LUM_BITS-1:0]  lum_lo;

   logic                 term_valid_in;
   logic                 term_valid_ff;
   logic [TERM_BITS-1:0] num_in;
   logic [TERM_BITS-1:0] num_ff;
   logic [TERM_BITS-1:0] den_in;
   logic [TERM_BITS-1:0] den_ff;

   logic                  div_valid;
   logic [RATIO_BITS-1:0] div_quo;
   logic                  div_ovf;

   logic        rsp_valid_in;
   logic        rsp_valid_ff;
   crc_rsp_type rsp_in;
   crc_rsp_type rsp_ff;

   assign busy     = reset;
   assign in_valid = start && !busy;

   crc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   crc_luma #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_luma (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid),
      .in_data    (req_data),
      .cfg        (cfg),
      .out_valid  (lum_valid),
      .out_fg_lum (fg_lum),
      .out_bg_lum (bg_lum)
   );

   // 20 * L + 1.0 is the luminance plus 0.05, scaled by 20.
   always_comb begin
      lum_hi        = (fg_lum >= bg_lum) ? fg_lum : bg_lum;
      lum_lo        = (fg_lum >= bg_lum) ? bg_lum : fg_lum;
      num_in        = (TERM_BITS'(lum_hi) << 4) + (TERM_BITS'(lum_hi) << 2) + TERM_ONE;
      den_in        = (TERM_BITS'(lum_lo) << 4) + (TERM_BITS'(lum_lo) << 2) + TERM_ONE;
      term_valid_in = lum_valid;
   end

   crc_div #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (term_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_ovf   (div_ovf)
   );

   always_comb begin
      if (div_ovf || (div_quo > RATIO_LIMIT)) begin
         rsp_in.contrast_ratio = RATIO_LIMIT;
      end else begin
         rsp_in.contrast_ratio = div_quo;
      end
      rsp_in.meets_guideline = (rsp_in.contrast_ratio > cfg.pass_threshold);
      rsp_valid_in           = div_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         term_valid_ff <= term_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("item did not produce a result at the expected latency");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching accepted item");

   a_ratio_at_least_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.contrast_ratio >= RATIO_ONE))
      else $error("contrast ratio below 1.0");

endmodule
